// ----- rtl/core/bui_pkg.sv -----
// Shared types and constants for the bounded uniform integer mapper.
package bui_pkg;

   localparam int DataWidth   = 32;
   localparam int ProdWidth   = 2 * DataWidth;
   localparam int CsrIdxWidth = 8;

   localparam logic [CsrIdxWidth-1:0] CsrLowLimit  = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CsrHighLimit = 8'd1;

   localparam logic signed [DataWidth-1:0] LowLimitReset  = 32'sd0;
   localparam logic signed [DataWidth-1:0] HighLimitReset = 32'sd255;

   // config register -> ordered limits -> span flags -> remainder unit load
   localparam logic [1:0] SettleCycles = 2'd3;

   localparam int DivCntWidth = 5;
   localparam logic [DivCntWidth-1:0] DivLastStep = 5'd31;

   localparam int FifoPtrWidth = 2;
   localparam int FifoDepth    = 4;
   localparam int FifoCntWidth = FifoPtrWidth + 1;
   localparam logic [FifoCntWidth-1:0] FifoFullCount = 3'd4;

   typedef enum logic {
      KIND_DIRECT,
      KIND_LEMIRE
   } item_kind_type;

   // queue entry: finished value for direct items, raw word for multiply items
   typedef struct packed {
      item_kind_type         kind;
      logic [DataWidth-1:0]  data;
   } item_type;

   typedef struct packed {
      logic                  ready;
      logic                  full;
      logic                  pow2;
      logic [DataWidth-1:0]  low;
      logic [DataWidth-1:0]  mask;
      logic [DataWidth-1:0]  bound;
      logic [DataWidth-1:0]  threshold;
   } cfg_type;

endpackage

// ----- rtl/core/bui_cfg.sv -----
// Limit registers, derived span values and the serial rejection-threshold unit.
module bui_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bui_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [bui_pkg::DataWidth-1:0]   csr_data,
   output bui_pkg::cfg_type                cfg
);
   import bui_pkg::*;

   logic signed [DataWidth-1:0] low_ff, low_in;
   logic signed [DataWidth-1:0] high_ff, high_in;
   logic [DataWidth-1:0]        lo_a_ff, lo_a_in;
   logic [DataWidth-1:0]        span_a_ff, span_a_in;
   logic [DataWidth-1:0]        lo_b_ff, lo_b_in;
   logic [DataWidth-1:0]        mask_b_ff, mask_b_in;
   logic [DataWidth-1:0]        bound_ff, bound_in;
   logic                        pow2_ff, pow2_in;
   logic                        full_ff, full_in;
   logic [1:0]                  hold_ff, hold_in;
   logic                        busy_ff, busy_in;
   logic [DivCntWidth-1:0]      cnt_ff, cnt_in;
   logic [DataWidth-1:0]        rem_ff, rem_in;
   logic [DataWidth-1:0]        dvd_ff, dvd_in;
   logic                        csr_write;
   logic                        swap;
   logic [DataWidth:0]          shifted;
   logic [DataWidth:0]          trial;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_write && csr_index == CsrLowLimit) begin
         low_in = csr_data;
      end
      if (csr_write && csr_index == CsrHighLimit) begin
         high_in = csr_data;
      end
   end

   // order the limits, span minus one is the unsigned difference
   always_comb begin
      swap      = low_ff > high_ff;
      lo_a_in   = swap ? high_ff : low_ff;
      span_a_in = swap ? DataWidth'(low_ff - high_ff) : DataWidth'(high_ff - low_ff);
      lo_b_in   = lo_a_ff;
      mask_b_in = span_a_ff;
      bound_in  = span_a_ff + 32'd1;
      pow2_in   = ((span_a_ff + 32'd1) & span_a_ff) == '0;
      full_in   = &span_a_ff;
   end

   // restoring remainder of (2^32 - bound) by bound, one bit a cycle
   always_comb begin
      hold_in = (hold_ff != 2'd0) ? hold_ff - 2'd1 : hold_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      shifted = {rem_ff, dvd_ff[DataWidth-1]};
      trial   = shifted - {1'b0, bound_ff};
      if (csr_write) begin
         hold_in = SettleCycles;
         busy_in = 1'b0;
      end else if (hold_ff == 2'd1) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = 32'd0 - bound_ff;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DataWidth-2:0], 1'b0};
         rem_in = trial[DataWidth] ? shifted[DataWidth-1:0] : trial[DataWidth-1:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == DivLastStep) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= LowLimitReset;
         high_ff <= HighLimitReset;
         hold_ff <= SettleCycles;
         busy_ff <= 1'b0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
         hold_ff <= hold_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_a_ff   <= lo_a_in;
      span_a_ff <= span_a_in;
      lo_b_ff   <= lo_b_in;
      mask_b_ff <= mask_b_in;
      bound_ff  <= bound_in;
      pow2_ff   <= pow2_in;
      full_ff   <= full_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
   end

   always_comb begin
      cfg.ready     = (hold_ff == 2'd0) && !busy_ff;
      cfg.full      = full_ff;
      cfg.pow2      = pow2_ff;
      cfg.low       = lo_b_ff;
      cfg.mask      = mask_b_ff;
      cfg.bound     = bound_ff;
      cfg.threshold = rem_ff;
   end

endmodule

// ----- rtl/core/bui_front.sv -----
// Input stage: accepts random words and classifies them by range kind.
module bui_front (
   input  logic                          clock,
   input  logic                          reset,
   input  bui_pkg::cfg_type              cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bui_pkg::DataWidth-1:0] req_tdata,
   output logic                          push,
   output bui_pkg::item_type             push_item,
   input  logic                          fifo_full
);
   import bui_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign push       = valid_ff && !fifo_full;
   assign push_item  = item_ff;
   assign req_tready = cfg.ready && (!valid_ff || !fifo_full);
   assign accept     = req_tvalid && req_tready;

   // full range and power-of-two spans finish here; others go to the multiplier
   always_comb begin
      valid_in = accept || (valid_ff && !push);
      item_in  = item_ff;
      if (accept) begin
         if (cfg.full) begin
            item_in.kind = KIND_DIRECT;
            item_in.data = req_tdata;
         end else if (cfg.pow2) begin
            item_in.kind = KIND_DIRECT;
            item_in.data = cfg.low + (req_tdata & cfg.mask);
         end else begin
            item_in.kind = KIND_LEMIRE;
            item_in.data = req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ----- rtl/core/bui_fifo.sv -----
// Short queue between the classify stage and the multiply stage.
module bui_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bui_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output bui_pkg::item_type pop_item,
   output logic              empty
);
   import bui_pkg::*;

   item_type                  mem_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntWidth-1:0]   count_ff, count_in;

   assign full     = count_ff == FifoFullCount;
   assign empty    = count_ff == '0;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 3'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/bui_back.sv -----
// Multiply stage, rejection test and output register.
module bui_back (
   input  logic                          clock,
   input  logic                          reset,
   input  bui_pkg::cfg_type              cfg,
   input  logic                          empty,
   input  bui_pkg::item_type             pop_item,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bui_pkg::DataWidth-1:0] rsp_tdata
);
   import bui_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   item_kind_type         s1_kind_ff, s1_kind_in;
   logic [ProdWidth-1:0]  s1_prod_ff, s1_prod_in;
   logic                  out_valid_ff, out_valid_in;
   logic [DataWidth-1:0]  out_data_ff, out_data_in;
   logic                  out_free;
   logic                  s1_go;
   logic                  reject;
   logic [DataWidth-1:0]  value;

   assign out_free = !out_valid_ff || rsp_tready;
   assign s1_go    = s1_valid_ff && out_free;
   assign pop      = !empty && (!s1_valid_ff || s1_go);

   // high half of word * span is the offset into the range
   always_comb begin
      s1_kind_in = s1_kind_ff;
      s1_prod_in = s1_prod_ff;
      if (pop) begin
         s1_kind_in = pop_item.kind;
         if (pop_item.kind == KIND_LEMIRE) begin
            s1_prod_in = ProdWidth'(pop_item.data) * ProdWidth'(cfg.bound);
         end else begin
            s1_prod_in = {pop_item.data, {DataWidth{1'b0}}};
         end
      end
      s1_valid_in = pop || (s1_valid_ff && !s1_go);
   end

   // drop the word when the low half falls in the biased zone
   always_comb begin
      reject = (s1_kind_ff == KIND_LEMIRE) && (s1_prod_ff[DataWidth-1:0] < cfg.threshold);
      value  = s1_prod_ff[ProdWidth-1:DataWidth];
      if (s1_kind_ff == KIND_LEMIRE) begin
         value = s1_prod_ff[ProdWidth-1:DataWidth] + cfg.low;
      end
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      if (s1_go) begin
         out_valid_in = !reject;
         out_data_in  = value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff  <= s1_kind_in;
      s1_prod_ff  <= s1_prod_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- rtl/core/bounded_uniform_int_mapper_unit.sv -----
// Bounded uniform integer mapper: maps raw 32-bit random words onto a signed
// inclusive range [low, high] without bias. Full-range and power-of-two spans
// map every word; other spans use multiply-and-reject, so some words give no
// result. One word is accepted per cycle while the configuration is ready and
// the classify stage can hand its word on. Each word passes the classify,
// queue, product and output registers; a four-entry queue between the classify
// stage and the 32x32 multiply stage decouples the input from output
// backpressure. After reset and after every configuration write the input is
// held off while the span values settle and the bit-serial threshold unit runs.
module bounded_uniform_int_mapper_unit (
   input  logic                            clock,
   input  logic                            reset,
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bui_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [bui_pkg::DataWidth-1:0]   csr_data,
   // random words in
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bui_pkg::DataWidth-1:0]   req_tdata,   // [31:0] random_word
   // samples out
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bui_pkg::DataWidth-1:0]   rsp_tdata    // [31:0] sample_value
);
   import bui_pkg::*;

   cfg_type  cfg;
   logic     push;
   item_type push_item;
   logic     fifo_full;
   logic     pop;
   item_type pop_item;
   logic     fifo_empty;

   bui_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bui_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_item  (push_item),
      .fifo_full  (fifo_full)
   );

   bui_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (fifo_empty)
   );

   bui_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .empty      (fifo_empty),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
